>>> hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Send schedule table package
// Shared types and codes for the send schedule table.
// ----------------------------------------------------------------------------
package sst_pkg;
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_GUARD  = 3'd2;
  localparam logic [2:0] ACT_GAP    = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_GUARD = 1'b0;
  localparam logic REG_MAXTX = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] time_value;
    logic [7:0]  node_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        guard_ok;
    logic        gap_found;
    logic [31:0] slot_start;
    logic [31:0] slot_end;
    logic        head_valid;
    logic [31:0] head_time;
    logic [7:0]  head_node;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tm;
    logic [7:0]  node;
  } entry_t;

  typedef struct packed {
    logic        shift_down;
    logic        ins;
    logic [31:0] tm;
    logic [7:0]  node;
  } cell_ctl_t;
endpackage

>>> hdl/sst_if.sv
// ----------------------------------------------------------------------------
// Send schedule table channels
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface sst_req_if;
  logic             valid;
  logic             ready;
  sst_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sst_rsp_if;
  logic             valid;
  logic             ready;
  sst_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sst_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [23:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hdl/sst_cell.sv
// ----------------------------------------------------------------------------
// Send schedule table cell
// Holds one entry; loads from its lower or upper neighbor or the new item.
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic              clk,
  input  logic              rst,
  input  sst_pkg::cell_ctl_t ctl,
  input  sst_pkg::entry_t   from_lower,
  input  sst_pkg::entry_t   from_upper,
  output sst_pkg::entry_t   q
);
  import sst_pkg::*;

  entry_t     ent;
  logic [0:0] goes_up;
  logic       take_new;
  logic       take_lower;

  // Insert: take lower if its time > t; the first cell past t or empty takes new.
  assign goes_up    = ent.valid && (ent.tm > ctl.tm);
  assign take_lower = from_lower.valid && (from_lower.tm > ctl.tm);
  assign take_new   = !take_lower && from_lower.valid && (goes_up[0] || !ent.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.shift_down) begin
      ent <= from_upper;
    end else if (ctl.ins) begin
      if (take_lower) begin
        ent <= from_lower;
      end else if (take_new) begin
        ent <= '{valid: 1'b1, tm: ctl.tm, node: ctl.node};
      end
    end
  end

  assign q = ent;
endmodule

>>> hdl/sst_ctrl.sv
// ----------------------------------------------------------------------------
// Send schedule table sequencer
// Walks the cell row for searches, drives inserts, clears and head pops, and forms results.
// ----------------------------------------------------------------------------
module sst_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sst_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sst_pkg::rsp_t      rsp,
  input  logic [23:0]        guard_time,
  input  logic [23:0]        max_tx_time,
  input  sst_pkg::entry_t    scan,
  output logic [$clog2(DEPTH)-1:0] scan_idx,
  input  sst_pkg::entry_t    head,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output sst_pkg::cell_ctl_t ctl
);
  import sst_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_CLR  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  req_t        cur;
  logic [CW-1:0] pos;
  logic        have_prev;
  logic [31:0] prev;
  logic [1:0]  status;
  logic        guard_ok;
  logic        gap_found;
  logic [31:0] slot_start;
  logic [31:0] slot_end;
  logic        done;
  logic [32:0] span;
  logic [33:0] need;
  logic [32:0] sat;
  logic [31:0] diff;
  logic        in_range;

  assign span     = {9'd0, guard_time} + {9'd0, max_tx_time};
  assign need     = {10'd0, guard_time} + {1'b0, span};
  assign sat      = {1'b0, prev} + span;
  assign diff     = scan.tm - prev;
  assign in_range = pos < count;
  assign scan_idx = pos[IW-1:0];
  assign req_ready = (state == S_IDLE) && !rsp_valid;

  always_comb begin
    ctl = '{shift_down: 1'b0, ins: 1'b0, tm: cur.time_value, node: cur.node_id};
    if (state == S_WALK && cur.action == ACT_INSERT && count != CW'(DEPTH)) begin
      ctl.ins = 1'b1;
    end
    if (state == S_WALK && cur.action == ACT_POP && count != '0) begin
      ctl.shift_down = 1'b1;
    end
    if (state == S_CLR && count != '0 && head.tm < cur.time_value) begin
      ctl.shift_down = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cur        <= req;
            pos        <= '0;
            have_prev  <= 1'b0;
            prev       <= '0;
            status     <= ST_DONE;
            guard_ok   <= 1'b0;
            gap_found  <= 1'b0;
            slot_start <= '0;
            slot_end   <= '0;
            done       <= 1'b0;
            state      <= (req.action == ACT_CLEAR) ? S_CLR : S_WALK;
          end
        end
        S_WALK: begin
          case (cur.action)
            ACT_INSERT: begin
              if (count == CW'(DEPTH)) begin
                status <= ST_FULL;
              end
              state <= S_OUT;
            end
            ACT_POP: begin
              if (count == '0) begin
                status <= ST_EMPTY;
              end
              state <= S_OUT;
            end
            ACT_GUARD: begin
              if (in_range && cur.time_value > scan.tm) begin
                prev      <= scan.tm;
                have_prev <= 1'b1;
                pos       <= pos + 1'b1;
              end else begin
                guard_ok <= !(have_prev && ((cur.time_value - prev) < {8'd0, guard_time}))
                         && !(in_range && ({1'b0, scan.tm - cur.time_value} <= span));
                state <= S_OUT;
              end
            end
            ACT_GAP: begin
              if (!done) begin
                if (in_range && cur.time_value > scan.tm) begin
                  prev <= scan.tm;
                  pos  <= pos + 1'b1;
                end else begin
                  done <= 1'b1;
                end
              end else if (in_range) begin
                if (scan.tm > prev && {2'd0, diff} > need) begin
                  gap_found  <= 1'b1;
                  slot_start <= sat[31:0];
                  slot_end   <= scan.tm - {8'd0, guard_time};
                  state      <= S_OUT;
                end else begin
                  prev <= scan.tm;
                  pos  <= pos + 1'b1;
                end
              end else begin
                slot_start <= sat[32] ? 32'hFFFF_FFFF : sat[31:0];
                state      <= S_OUT;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_CLR: begin
          if (!(count != '0 && head.tm < cur.time_value)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rsp.status      = status;
    rsp.guard_ok    = guard_ok;
    rsp.gap_found   = gap_found;
    rsp.slot_start  = slot_start;
    rsp.slot_end    = slot_end;
    rsp.head_valid  = count != '0;
    rsp.head_time   = (count != '0) ? head.tm : 32'd0;
    rsp.head_node   = (count != '0) ? head.node : 8'd0;
    rsp.entry_count = 5'(count);
  end
endmodule

>>> hdl/send_schedule_table_core.sv
// ----------------------------------------------------------------------------
// Send schedule table core
// Time-sorted table of scheduled sends built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each gives exactly one result on the
// rsp channel. Configuration writes on the cfg channel set the guard time
// (index 0) and the longest transmit time (index 1); they are always ready.
// An insert or pop passes through the walk and output states before its result
// is valid; the cell row shifts all entries at once. A guard check walks the
// row one entry a cycle through a read mux, and a gap search walks it as well.
// A clear pops one expired head a cycle. The next request is taken in the
// cycle after the result has been transferred.
// Reset empties the table and clears both registers; a stalled receiver
// holds the result steady and blocks new requests.
// ----------------------------------------------------------------------------
module send_schedule_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  sst_req_if.sink   req,
  sst_rsp_if.source rsp,
  sst_cfg_if.sink   cfg
);
  import sst_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [23:0]  guard_time;
  logic [23:0]  max_tx_time;
  entry_t       cells [TABLE_DEPTH];
  entry_t       lower [TABLE_DEPTH];
  entry_t       upper [TABLE_DEPTH];
  cell_ctl_t    ctl;
  logic [IW-1:0] scan_idx;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_time  <= '0;
      max_tx_time <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_GUARD) begin
        guard_time <= cfg.wdata;
      end else begin
        max_tx_time <= cfg.wdata;
      end
    end
  end

  always_comb begin
    count_next = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      count_next = count_next + CW'(cells[i].valid);
    end
  end
  assign count = count_next;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      // The first cell sees a valid entry at time zero below it.
      assign lower[g] = '{valid: 1'b1, tm: 32'd0, node: 8'd0};
    end else begin : g_mid
      assign lower[g] = cells[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign upper[g] = '0;
    end else begin : g_up
      assign upper[g] = cells[g+1];
    end
    sst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .from_lower (lower[g]),
      .from_upper (upper[g]),
      .q          (cells[g])
    );
  end

  sst_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req         (req.data),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp         (rsp.data),
    .guard_time  (guard_time),
    .max_tx_time (max_tx_time),
    .scan        (cells[scan_idx]),
    .scan_idx    (scan_idx),
    .head        (cells[0]),
    .count       (count),
    .ctl         (ctl)
  );
endmodule

>>> hdl/sst_checker.sv
// ----------------------------------------------------------------------------
// Send schedule table checker
// Port-level checks on the request and result channels, bound to the core.
// ----------------------------------------------------------------------------
module sst_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sst_pkg::rsp_t rsp_data
);
  import sst_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_no_take: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while a result waits");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.head_valid == (rsp_data.entry_count != 5'd0))
    else $error("head valid disagrees with count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.entry_count != 5'd0)
    else $error("full status on an empty table");
endmodule

bind send_schedule_table_core sst_checker u_sst_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

>>> sim/send_schedule_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Send schedule table core testbench
// Drives table requests and configuration writes. Each result is checked
// field by field against an in-bench model of the sorted table.
// ----------------------------------------------------------------------------
module send_schedule_table_core_tb;
  import sst_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sst_req_if req ();
  sst_rsp_if rsp ();
  sst_cfg_if cfg ();

  send_schedule_table_core #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  logic [31:0] tbl_time [DEPTH];
  logic [7:0]  tbl_node [DEPTH];
  int          tbl_used;
  logic [23:0] guard_reg;
  logic [23:0] maxtx_reg;

  rsp_t expected_rsps [$];
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  longint cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void drop_head_entry();
    for (int i = 1; i < tbl_used; i++) begin
      tbl_time[i-1] = tbl_time[i];
      tbl_node[i-1] = tbl_node[i];
    end
    tbl_used--;
  endfunction

  function automatic int first_not_below(input logic [31:0] t);
    int i;
    i = 0;
    while (i < tbl_used && t > tbl_time[i]) i++;
    return i;
  endfunction

  function automatic rsp_t predict_schedule(input req_t r);
    rsp_t o;
    int pos;
    logic [63:0] span, need, prev, nxt, v;
    o = '0;
    span = 64'(guard_reg) + 64'(maxtx_reg);
    case (r.action)
      ACT_INSERT: begin
        if (tbl_used >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_used && tbl_time[pos] <= r.time_value) pos++;
          for (int i = tbl_used; i > pos; i--) begin
            tbl_time[i] = tbl_time[i-1];
            tbl_node[i] = tbl_node[i-1];
          end
          tbl_time[pos] = r.time_value;
          tbl_node[pos] = r.node_id;
          tbl_used++;
        end
      end
      ACT_POP: begin
        if (tbl_used == 0) o.status = ST_EMPTY;
        else drop_head_entry();
      end
      ACT_GUARD: begin
        pos = first_not_below(r.time_value);
        o.guard_ok = 1'b1;
        if (pos > 0 && 64'(r.time_value - tbl_time[pos-1]) < 64'(guard_reg))
          o.guard_ok = 1'b0;
        if (pos < tbl_used && 64'(tbl_time[pos] - r.time_value) <= span)
          o.guard_ok = 1'b0;
      end
      ACT_GAP: begin
        pos = first_not_below(r.time_value);
        prev = (pos > 0) ? 64'(tbl_time[pos-1]) : 64'd0;
        need = 2 * 64'(guard_reg) + 64'(maxtx_reg);
        for (; pos < tbl_used; pos++) begin
          nxt = 64'(tbl_time[pos]);
          if (nxt > prev && nxt - prev > need) begin
            o.gap_found = 1'b1;
            o.slot_start = 32'(prev + span);
            o.slot_end = 32'(nxt - 64'(guard_reg));
            break;
          end
          prev = nxt;
        end
        if (!o.gap_found) begin
          v = prev + span;
          o.slot_start = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
        end
      end
      ACT_CLEAR: begin
        while (tbl_used > 0 && tbl_time[0] < r.time_value) drop_head_entry();
      end
      default: ;
    endcase
    o.head_valid = tbl_used > 0;
    o.head_time = tbl_used > 0 ? tbl_time[0] : 32'd0;
    o.head_node = tbl_used > 0 ? tbl_node[0] : 8'd0;
    o.entry_count = 5'(tbl_used);
    return o;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("MISMATCH unexpected result transfer at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.data.status !== want.status)
          report_mismatch("status", 32'(rsp.data.status), 32'(want.status));
        if (rsp.data.guard_ok !== want.guard_ok)
          report_mismatch("guard_ok", 32'(rsp.data.guard_ok), 32'(want.guard_ok));
        if (rsp.data.gap_found !== want.gap_found)
          report_mismatch("gap_found", 32'(rsp.data.gap_found), 32'(want.gap_found));
        if (rsp.data.slot_start !== want.slot_start)
          report_mismatch("slot_start", rsp.data.slot_start, want.slot_start);
        if (rsp.data.slot_end !== want.slot_end)
          report_mismatch("slot_end", rsp.data.slot_end, want.slot_end);
        if (rsp.data.head_valid !== want.head_valid)
          report_mismatch("head_valid", 32'(rsp.data.head_valid), 32'(want.head_valid));
        if (rsp.data.head_time !== want.head_time)
          report_mismatch("head_time", rsp.data.head_time, want.head_time);
        if (rsp.data.head_node !== want.head_node)
          report_mismatch("head_node", 32'(rsp.data.head_node), 32'(want.head_node));
        if (rsp.data.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp.data.entry_count),
                          32'(want.entry_count));
      end
    end
  end

  task automatic send_request(input logic [2:0] action, input logic [31:0] t,
                              input logic [7:0] node);
    req_t r;
    r.action = action;
    r.time_value = t;
    r.node_id = node;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    req.valid = 1'b1;
    req.data = r;
    do @(posedge clk); while (!req.ready);
    expected_rsps.push_back(predict_schedule(r));
    @(negedge clk);
    req.valid = 1'b0;
    req.data = $bits(req_t)'({$urandom, $urandom});
  endtask

  task automatic wait_drained();
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (2 * DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [23:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.wdata = value;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_GUARD) guard_reg = value;
    else maxtx_reg = value;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_timing(input logic [23:0] g, input logic [23:0] m);
    wait_drained();
    write_register(REG_GUARD, g);
    write_register(REG_MAXTX, m);
  endtask

  // Most times cluster in a narrow band so that spacing rules bite; some are random or near either end.
  function automatic logic [31:0] pick_time(input logic [31:0] base);
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(300);
      2: return $urandom_range(300);
      default: return base + $urandom_range(400);
    endcase
  endfunction

  task automatic test_directed();
    send_request(ACT_POP, 32'd0, 8'd0);
    send_request(ACT_GUARD, 32'd100, 8'd0);
    send_request(ACT_GAP, 32'd0, 8'd0);
    send_request(ACT_CLEAR, 32'hFFFF_FFFF, 8'd0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_request(ACT_INSERT, 32'd0, 8'h00);
    send_request(ACT_INSERT, 32'd500, 8'h11);
    send_request(ACT_INSERT, 32'd500, 8'h22);
    send_request(ACT_GUARD, 32'd500, 8'd0);
    send_request(ACT_GUARD, 32'd250, 8'd0);
    send_request(ACT_GAP, 32'd1, 8'd0);
    send_request(ACT_GAP, 32'hFFFF_FFFF, 8'd0);
    for (int i = 0; i < 14; i++)
      send_request(ACT_INSERT, 32'd1000 + i * 10, 8'(i));
    send_request(3'd5, 32'd7, 8'd1);
    send_request(3'd7, 32'hFFFF_FFFF, 8'hFF);
    send_request(ACT_CLEAR, 32'd1000, 8'd0);
    send_request(ACT_POP, 32'd0, 8'd0);
  endtask

  task automatic test_random(input int count);
    logic [31:0] base;
    int sel;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 35) send_request(ACT_INSERT, pick_time(base), 8'($urandom));
      else if (sel < 50) send_request(ACT_POP, $urandom, 8'($urandom));
      else if (sel < 67) send_request(ACT_GUARD, pick_time(base), 8'($urandom));
      else if (sel < 84) send_request(ACT_GAP, pick_time(base), 8'($urandom));
      else if (sel < 96) send_request(ACT_CLEAR, pick_time(base), 8'($urandom));
      else send_request(3'($urandom_range(7, 5)), $urandom, 8'($urandom));
      if ($urandom_range(199) == 0) begin
        base = $urandom;
        if (base > 32'hFFFF_F000) base = 32'hFFFF_F000;
      end
    end
  endtask

  task automatic test_idle_phases();
    set_timing(24'd3, 24'd5);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(300);
    set_timing(24'hFF_FFFF, 24'hFF_FFFF);
    send_idle_pct = 88; recv_stall_pct = 0;
    test_random(250);
    set_timing(24'd0, 24'd0);
    send_idle_pct = 0; recv_stall_pct = 88;
    test_random(250);
    set_timing(24'($urandom_range(40)), 24'($urandom_range(60)));
    send_idle_pct = 25; recv_stall_pct = 25;
    test_random(250);
    set_timing(24'($urandom), 24'($urandom));
    test_random(100);
  endtask

  task automatic test_drained_pause();
    set_timing(24'd10, 24'd20);
    send_idle_pct = 0; recv_stall_pct = 50;
    for (int i = 0; i < 5; i++) begin
      test_random(30);
      wait_drained();
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.index = 1'b0;
    cfg.wdata = '0;
    rsp.ready = 1'b0;
    tbl_used = 0;
    guard_reg = '0;
    maxtx_reg = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_idle_phases();
    test_drained_pause();
    wait_drained();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
